/* src/irqc_pkg.sv */
// Shared types and constants of the IRQ/FIQ interrupt controller.
package irqc_pkg;

    localparam int NUM_SOURCES = 32;
    localparam logic [31:0] ALL_ONES  = 32'hffff_ffff;
    localparam logic [31:0] LINE_MASK = ALL_ONES >> (32 - NUM_SOURCES);
    localparam logic [1:0]  MEN_RESET = 2'd3;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_LINE  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    localparam logic [4:0] REG_ENABLE     = 5'd0;
    localparam logic [4:0] REG_CLEAR_REQ  = 5'd1;
    localparam logic [4:0] REG_PENDING    = 5'd2;
    localparam logic [4:0] REG_IRQ_SELECT = 5'd3;
    localparam logic [4:0] REG_SRC_STATUS = 5'd4;
    localparam logic [4:0] REG_MASKED     = 5'd5;
    localparam logic [4:0] REG_TEST_REQ   = 5'd6;
    localparam logic [4:0] REG_POLARITY   = 5'd7;
    localparam logic [4:0] REG_IRQ_STATUS = 5'd8;
    localparam logic [4:0] REG_FIQ_STATUS = 5'd9;
    localparam logic [4:0] REG_IRQ_LINE   = 5'd10;
    localparam logic [4:0] REG_FIQ_LINE   = 5'd11;
    localparam logic [4:0] REG_LEVEL_MODE = 5'd12;
    localparam logic [4:0] REG_SYNC       = 5'd13;
    localparam logic [4:0] REG_WAKEUP     = 5'd14;
    localparam logic [4:0] REG_EDGE_EN    = 5'd15;
    localparam logic [4:0] REG_OUT_EN     = 5'd16;
    localparam logic [4:0] REG_MEN_A      = 5'd17;
    localparam logic [4:0] REG_MEN_B      = 5'd18;

    typedef struct packed {
        t_op         operation;
        logic [4:0]  register_index;
        logic [31:0] write_data;
        logic [4:0]  line_number;
        logic        line_level;
    } t_item;

    typedef struct packed {
        logic [31:0] read_data;
        logic        irq_request;
        logic        fiq_request;
    } t_result;

endpackage

/* src/irq_fiq_interrupt_controller.sv */
// Top level of the 32-source IRQ/FIQ interrupt controller.
// Each accepted word is a register read, a register write or a change on one
// source line, and yields one result word: the read data (zero unless a read)
// and the IRQ and FIQ request flags as they stand after the word. A word is
// taken into an input register, then applied to the register state once the
// output register is free or being read, while its result is captured in the
// output register, from which it is shown. One word per cycle is sustained
// while the output is not stalled, with the output register holding a stalled
// result while the next word already waits in the input register.
module irq_fiq_interrupt_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_operation,
    input  logic [4:0]  i_register_index,
    input  logic [31:0] i_write_data,
    input  logic [4:0]  i_line_number,
    input  logic        i_line_level,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_read_data,
    output logic        o_irq_request,
    output logic        o_fiq_request
);

    logic              r_in_valid;
    irqc_pkg::t_item   r_item;
    logic              r_out_valid;
    irqc_pkg::t_result r_result;
    irqc_pkg::t_result n_result;
    logic              advance;
    logic              apply;

    assign advance    = !r_out_valid || i_out_ready;
    assign apply      = r_in_valid && advance;
    assign o_in_ready = !r_in_valid || advance;

    irqc_regs u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_apply  (apply),
        .i_item   (r_item),
        .o_result (n_result)
    );

    // hold the input word until the state stage takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_item.operation      <= irqc_pkg::t_op'(i_operation);
            r_item.register_index <= i_register_index;
            r_item.write_data     <= i_write_data;
            r_item.line_number    <= i_line_number;
            r_item.line_level     <= i_line_level;
        end
    end

    // advance the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (apply) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_read_data   = r_result.read_data;
    assign o_irq_request = r_result.irq_request;
    assign o_fiq_request = r_result.fiq_request;

endmodule

/* src/irqc_regs.sv */
// Register state of the controller with its update and read logic.
module irqc_regs (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_apply,
    input  irqc_pkg::t_item  i_item,
    output irqc_pkg::t_result o_result
);

    logic [31:0] r_pend, n_pend;
    logic [31:0] r_line, n_line;
    logic [31:0] r_en, n_en;
    logic [31:0] r_sel, n_sel;
    logic [31:0] r_pol, n_pol;
    logic [31:0] r_lvm, n_lvm;
    logic [31:0] r_edge, n_edge;
    logic [31:0] r_oen, n_oen;
    logic [1:0]  r_men_a, n_men_a;
    logic [1:0]  r_men_b, n_men_b;
    logic [31:0] r_sync, n_sync;
    logic [31:0] r_wake, n_wake;

    logic        apply_lv;
    logic [31:0] bit_sel;
    logic [31:0] edge_ok;
    logic [31:0] active;
    logic [31:0] idle;
    logic [31:0] status;
    logic        men_ok;
    logic [31:0] rd;

    always_comb begin
        n_pend  = r_pend;
        n_line  = r_line;
        n_en    = r_en;
        n_sel   = r_sel;
        n_pol   = r_pol;
        n_lvm   = r_lvm;
        n_edge  = r_edge;
        n_oen   = r_oen;
        n_men_a = r_men_a;
        n_men_b = r_men_b;
        n_sync  = r_sync;
        n_wake  = r_wake;
        apply_lv = 1'b0;
        bit_sel = (32'd1 << i_item.line_number) & irqc_pkg::LINE_MASK;
        edge_ok = r_edge & ~r_lvm;
        if (i_apply) begin
            unique case (i_item.operation)
                irqc_pkg::OP_WRITE: begin
                    unique case (i_item.register_index)
                        irqc_pkg::REG_ENABLE:     n_en = i_item.write_data;
                        irqc_pkg::REG_CLEAR_REQ: begin
                            n_pend   = r_pend & ~i_item.write_data;
                            apply_lv = 1'b1;
                        end
                        irqc_pkg::REG_PENDING:    n_pend = r_pend & ~i_item.write_data;
                        irqc_pkg::REG_IRQ_SELECT: n_sel = i_item.write_data;
                        irqc_pkg::REG_TEST_REQ:   n_pend = r_pend | i_item.write_data;
                        irqc_pkg::REG_POLARITY: begin
                            n_pol    = i_item.write_data;
                            apply_lv = 1'b1;
                        end
                        irqc_pkg::REG_LEVEL_MODE: begin
                            n_lvm    = i_item.write_data;
                            apply_lv = 1'b1;
                        end
                        irqc_pkg::REG_SYNC:       n_sync = i_item.write_data;
                        irqc_pkg::REG_WAKEUP:     n_wake = i_item.write_data;
                        irqc_pkg::REG_EDGE_EN:    n_edge = i_item.write_data;
                        irqc_pkg::REG_OUT_EN:     n_oen = i_item.write_data;
                        irqc_pkg::REG_MEN_A:      n_men_a = i_item.write_data[1:0];
                        irqc_pkg::REG_MEN_B:      n_men_b = i_item.write_data[1:0];
                        default: ;
                    endcase
                end
                irqc_pkg::OP_LINE: begin
                    if (32'(i_item.line_number) < 32'(irqc_pkg::NUM_SOURCES)) begin
                        apply_lv = 1'b1;
                        if (i_item.line_level) begin
                            n_line = r_line | bit_sel;
                            if (((r_line & bit_sel) == '0)
                                    && ((edge_ok & ~r_pol & bit_sel) != '0)) begin
                                n_pend = r_pend | bit_sel;
                            end
                        end else begin
                            n_line = r_line & ~bit_sel;
                            if (((r_line & bit_sel) != '0)
                                    && ((edge_ok & r_pol & bit_sel) != '0)) begin
                                n_pend = r_pend | bit_sel;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
        active = (n_line ^ n_pol) & n_lvm;
        idle   = (~n_line ^ n_pol) & n_lvm;
        if (apply_lv) begin
            n_pend = (n_pend | active) & ~idle;
        end
    end

    always_comb begin
        status = r_line ^ r_pol;
        men_ok = r_men_a[0] & r_men_b[0];
        rd     = '0;
        if (i_item.operation == irqc_pkg::OP_READ) begin
            unique case (i_item.register_index)
                irqc_pkg::REG_ENABLE:     rd = r_en;
                irqc_pkg::REG_PENDING:    rd = r_pend;
                irqc_pkg::REG_IRQ_SELECT: rd = r_sel;
                irqc_pkg::REG_SRC_STATUS: rd = status;
                irqc_pkg::REG_MASKED:     rd = r_pend & r_en;
                irqc_pkg::REG_POLARITY:   rd = r_pol;
                irqc_pkg::REG_IRQ_STATUS: rd = r_pend & r_sel;
                irqc_pkg::REG_FIQ_STATUS: rd = r_pend & ~r_sel;
                irqc_pkg::REG_IRQ_LINE:   rd = men_ok ? (status & r_en & r_sel & r_oen) : '0;
                irqc_pkg::REG_FIQ_LINE:   rd = men_ok ? (status & r_en & ~r_sel & r_oen) : '0;
                irqc_pkg::REG_LEVEL_MODE: rd = r_lvm;
                irqc_pkg::REG_SYNC:       rd = r_sync;
                irqc_pkg::REG_WAKEUP:     rd = r_wake;
                irqc_pkg::REG_EDGE_EN:    rd = r_edge;
                irqc_pkg::REG_OUT_EN:     rd = r_oen;
                irqc_pkg::REG_MEN_A:      rd = {30'd0, r_men_a};
                irqc_pkg::REG_MEN_B:      rd = {30'd0, r_men_b};
                default:                  rd = '0;
            endcase
        end
        o_result.read_data   = rd;
        o_result.irq_request = ((n_pend & n_sel & n_en) != '0) && n_men_a[0];
        o_result.fiq_request = ((n_pend & ~n_sel & n_en) != '0) && n_men_a[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= '0;
            r_line  <= '0;
            r_en    <= '0;
            r_sel   <= '0;
            r_pol   <= '0;
            r_lvm   <= '0;
            r_edge  <= '0;
            r_oen   <= irqc_pkg::ALL_ONES;
            r_men_a <= irqc_pkg::MEN_RESET;
            r_men_b <= irqc_pkg::MEN_RESET;
            r_sync  <= '0;
            r_wake  <= '0;
        end else begin
            r_pend  <= n_pend;
            r_line  <= n_line;
            r_en    <= n_en;
            r_sel   <= n_sel;
            r_pol   <= n_pol;
            r_lvm   <= n_lvm;
            r_edge  <= n_edge;
            r_oen   <= n_oen;
            r_men_a <= n_men_a;
            r_men_b <= n_men_b;
            r_sync  <= n_sync;
            r_wake  <= n_wake;
        end
    end

endmodule

/* src/irqc_checker.sv */
// Port-level checks of the interrupt controller and their binding.
module irqc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_read_data,
    input logic        o_irq_request,
    input logic        o_fiq_request
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_accept_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> ##1 o_out_valid)
        else $error("accepted word produced no result");

    a_full_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with empty result register");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_read_data)
            && $stable(o_irq_request) && $stable(o_fiq_request)))
        else $error("stalled result changed");

endmodule

bind irq_fiq_interrupt_controller irqc_checker u_irqc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_read_data   (o_read_data),
    .o_irq_request (o_irq_request),
    .o_fiq_request (o_fiq_request)
);

/* sim/irq_fiq_interrupt_controller_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench of the IRQ/FIQ interrupt controller with a built-in register model.
module irq_fiq_interrupt_controller_tb;

    localparam int CYCLE_LIMIT = 200000;
    localparam int WORDS_PER_PHASE = 190;
    localparam int NUM_PHASES = 4;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    irqc_pkg::t_item   in_word = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [31:0]       o_read_data;
    logic              o_irq_request;
    logic              o_fiq_request;

    irqc_pkg::t_item   pending_words[$];
    irqc_pkg::t_result expected_responses[$];
    int      idle_pct = 0;
    int      stall_pct = 0;
    int      error_count = 0;
    int      cycle_count = 0;
    bit      word_taken = 1'b0;

    logic [31:0] pend_bits;
    logic [31:0] line_lv;
    logic [31:0] src_en;
    logic [31:0] irq_sel;
    logic [31:0] pol_bits;
    logic [31:0] lvl_mode;
    logic [31:0] edge_en;
    logic [31:0] out_en;
    logic [1:0]  men_a;
    logic [1:0]  men_b;
    logic [31:0] sync_reg;
    logic [31:0] wake_reg;

    irq_fiq_interrupt_controller i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_operation      (in_word.operation),
        .i_register_index (in_word.register_index),
        .i_write_data     (in_word.write_data),
        .i_line_number    (in_word.line_number),
        .i_line_level     (in_word.line_level),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_read_data      (o_read_data),
        .o_irq_request    (o_irq_request),
        .o_fiq_request    (o_fiq_request)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic void reapply_levels();
        logic [31:0] active;
        logic [31:0] idle;
        active = (line_lv ^ pol_bits) & lvl_mode;
        idle = (~line_lv ^ pol_bits) & lvl_mode;
        pend_bits = (pend_bits | active) & ~idle;
    endfunction

    function automatic irqc_pkg::t_result predict_response(irqc_pkg::t_item w);
        irqc_pkg::t_result r;
        logic [31:0] status;
        logic [31:0] bit_mask;
        logic [31:0] edge_ok;
        logic        men_ok;
        r = '0;
        status = line_lv ^ pol_bits;
        men_ok = men_a[0] & men_b[0];
        case (w.operation)
            irqc_pkg::OP_READ: begin
                case (w.register_index)
                    irqc_pkg::REG_ENABLE:     r.read_data = src_en;
                    irqc_pkg::REG_PENDING:    r.read_data = pend_bits;
                    irqc_pkg::REG_IRQ_SELECT: r.read_data = irq_sel;
                    irqc_pkg::REG_SRC_STATUS: r.read_data = status;
                    irqc_pkg::REG_MASKED:     r.read_data = pend_bits & src_en;
                    irqc_pkg::REG_POLARITY:   r.read_data = pol_bits;
                    irqc_pkg::REG_IRQ_STATUS: r.read_data = pend_bits & irq_sel;
                    irqc_pkg::REG_FIQ_STATUS: r.read_data = pend_bits & ~irq_sel;
                    irqc_pkg::REG_IRQ_LINE:
                        r.read_data = men_ok ? (status & src_en & irq_sel & out_en) : '0;
                    irqc_pkg::REG_FIQ_LINE:
                        r.read_data = men_ok ? (status & src_en & ~irq_sel & out_en) : '0;
                    irqc_pkg::REG_LEVEL_MODE: r.read_data = lvl_mode;
                    irqc_pkg::REG_SYNC:       r.read_data = sync_reg;
                    irqc_pkg::REG_WAKEUP:     r.read_data = wake_reg;
                    irqc_pkg::REG_EDGE_EN:    r.read_data = edge_en;
                    irqc_pkg::REG_OUT_EN:     r.read_data = out_en;
                    irqc_pkg::REG_MEN_A:      r.read_data = {30'd0, men_a};
                    irqc_pkg::REG_MEN_B:      r.read_data = {30'd0, men_b};
                    default:                  r.read_data = '0;
                endcase
            end
            irqc_pkg::OP_WRITE: begin
                case (w.register_index)
                    irqc_pkg::REG_ENABLE:     src_en = w.write_data;
                    irqc_pkg::REG_CLEAR_REQ: begin
                        pend_bits &= ~w.write_data;
                        reapply_levels();
                    end
                    irqc_pkg::REG_PENDING:    pend_bits &= ~w.write_data;
                    irqc_pkg::REG_IRQ_SELECT: irq_sel = w.write_data;
                    irqc_pkg::REG_TEST_REQ:   pend_bits |= w.write_data;
                    irqc_pkg::REG_POLARITY: begin
                        pol_bits = w.write_data;
                        reapply_levels();
                    end
                    irqc_pkg::REG_LEVEL_MODE: begin
                        lvl_mode = w.write_data;
                        reapply_levels();
                    end
                    irqc_pkg::REG_SYNC:       sync_reg = w.write_data;
                    irqc_pkg::REG_WAKEUP:     wake_reg = w.write_data;
                    irqc_pkg::REG_EDGE_EN:    edge_en = w.write_data;
                    irqc_pkg::REG_OUT_EN:     out_en = w.write_data;
                    irqc_pkg::REG_MEN_A:      men_a = w.write_data[1:0];
                    irqc_pkg::REG_MEN_B:      men_b = w.write_data[1:0];
                    default: ;
                endcase
            end
            irqc_pkg::OP_LINE: begin
                if (int'(w.line_number) < irqc_pkg::NUM_SOURCES) begin
                    bit_mask = (32'd1 << w.line_number) & irqc_pkg::LINE_MASK;
                    edge_ok = edge_en & ~lvl_mode;
                    if (w.line_level) begin
                        if ((line_lv & bit_mask) == '0 && (edge_ok & ~pol_bits & bit_mask) != '0)
                            pend_bits |= bit_mask;
                        line_lv |= bit_mask;
                    end else begin
                        if ((line_lv & bit_mask) != '0 && (edge_ok & pol_bits & bit_mask) != '0)
                            pend_bits |= bit_mask;
                        line_lv &= ~bit_mask;
                    end
                    reapply_levels();
                end
            end
            default: ;
        endcase
        r.irq_request = (|(pend_bits & irq_sel & src_en)) && men_a[0];
        r.fiq_request = (|(pend_bits & ~irq_sel & src_en)) && men_a[1];
        return r;
    endfunction

    function automatic irqc_pkg::t_item make_word(irqc_pkg::t_op op, logic [4:0] idx,
                                                  logic [31:0] data, logic [4:0] nr,
                                                  logic lvl);
        irqc_pkg::t_item w;
        w.operation = op;
        w.register_index = idx;
        w.write_data = data;
        w.line_number = nr;
        w.line_level = lvl;
        return w;
    endfunction

    function automatic irqc_pkg::t_item random_word();
        irqc_pkg::t_item w;
        int          pick;
        logic [31:0] data;
        pick = $urandom_range(7);
        case (pick)
            0:       data = '0;
            1:       data = irqc_pkg::ALL_ONES;
            2:       data = 32'd1 << $urandom_range(31);
            default: data = $urandom;
        endcase
        w.write_data = data;
        w.line_number = 5'($urandom_range(31));
        w.line_level = 1'($urandom_range(1));
        w.register_index = ($urandom_range(9) == 0) ? 5'($urandom_range(31, 19))
                                                    : 5'($urandom_range(18));
        pick = $urandom_range(99);
        if (pick < 40)
            w.operation = irqc_pkg::OP_LINE;
        else if (pick < 70)
            w.operation = irqc_pkg::OP_WRITE;
        else if (pick < 96)
            w.operation = irqc_pkg::OP_READ;
        else
            w.operation = irqc_pkg::OP_NONE;
        return w;
    endfunction

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= stall_pct);
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || word_taken) begin
            if (pending_words.size() != 0 && $urandom_range(99) >= idle_pct) begin
                in_word <= pending_words.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        word_taken = i_rst_n && i_in_valid && o_in_ready;
        if (word_taken)
            expected_responses.push_back(predict_response(in_word));
    end

    always @(posedge i_clk) begin
        irqc_pkg::t_result exp_r;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_responses.size() == 0) begin
                $error("unexpected result: read_data %h irq %b fiq %b",
                       o_read_data, o_irq_request, o_fiq_request);
                error_count++;
            end else begin
                exp_r = expected_responses.pop_front();
                if (o_read_data !== exp_r.read_data) begin
                    $error("read_data: expected %h, actual %h", exp_r.read_data, o_read_data);
                    error_count++;
                end
                if (o_irq_request !== exp_r.irq_request) begin
                    $error("irq_request: expected %b, actual %b",
                           exp_r.irq_request, o_irq_request);
                    error_count++;
                end
                if (o_fiq_request !== exp_r.fiq_request) begin
                    $error("fiq_request: expected %b, actual %b",
                           exp_r.fiq_request, o_fiq_request);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic drain_words();
        while (pending_words.size() != 0 || i_in_valid || expected_responses.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        pend_bits = '0;
        line_lv = '0;
        src_en = '0;
        irq_sel = '0;
        pol_bits = '0;
        lvl_mode = '0;
        edge_en = '0;
        out_en = irqc_pkg::ALL_ONES;
        men_a = irqc_pkg::MEN_RESET;
        men_b = irqc_pkg::MEN_RESET;
        sync_reg = '0;
        wake_reg = '0;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        pending_words.push_back(make_word(irqc_pkg::OP_READ, irqc_pkg::REG_OUT_EN,
                                          '0, 5'd0, 1'b0));
        pending_words.push_back(make_word(irqc_pkg::OP_READ, irqc_pkg::REG_MEN_A,
                                          '0, 5'd0, 1'b0));
        pending_words.push_back(make_word(irqc_pkg::OP_WRITE, irqc_pkg::REG_ENABLE,
                                          irqc_pkg::ALL_ONES, 5'd0, 1'b0));
        pending_words.push_back(make_word(irqc_pkg::OP_WRITE, irqc_pkg::REG_EDGE_EN,
                                          irqc_pkg::ALL_ONES, 5'd0, 1'b0));
        pending_words.push_back(make_word(irqc_pkg::OP_WRITE, irqc_pkg::REG_POLARITY,
                                          32'h0000_ff00, 5'd0, 1'b0));
        pending_words.push_back(make_word(irqc_pkg::OP_LINE, irqc_pkg::REG_ENABLE,
                                          '0, 5'd0, 1'b1));
        pending_words.push_back(make_word(irqc_pkg::OP_LINE, irqc_pkg::REG_ENABLE,
                                          '0, 5'd0, 1'b1));
        pending_words.push_back(make_word(irqc_pkg::OP_LINE, irqc_pkg::REG_ENABLE,
                                          '0, 5'd8, 1'b1));
        pending_words.push_back(make_word(irqc_pkg::OP_LINE, irqc_pkg::REG_ENABLE,
                                          '0, 5'd8, 1'b0));
        pending_words.push_back(make_word(irqc_pkg::OP_WRITE, irqc_pkg::REG_IRQ_SELECT,
                                          32'h8000_0001, 5'd0, 1'b0));
        pending_words.push_back(make_word(irqc_pkg::OP_WRITE, irqc_pkg::REG_LEVEL_MODE,
                                          32'h8000_0000, 5'd0, 1'b0));
        pending_words.push_back(make_word(irqc_pkg::OP_LINE, irqc_pkg::REG_ENABLE,
                                          '0, 5'd31, 1'b1));
        pending_words.push_back(make_word(irqc_pkg::OP_READ, irqc_pkg::REG_PENDING,
                                          irqc_pkg::ALL_ONES, 5'd0, 1'b0));
        pending_words.push_back(make_word(irqc_pkg::OP_WRITE, irqc_pkg::REG_CLEAR_REQ,
                                          irqc_pkg::ALL_ONES, 5'd0, 1'b0));
        pending_words.push_back(make_word(irqc_pkg::OP_WRITE, irqc_pkg::REG_TEST_REQ,
                                          32'h00ff_0000, 5'd0, 1'b0));
        pending_words.push_back(make_word(irqc_pkg::OP_READ, irqc_pkg::REG_IRQ_LINE,
                                          '0, 5'd0, 1'b0));
        pending_words.push_back(make_word(irqc_pkg::OP_READ, irqc_pkg::REG_FIQ_LINE,
                                          '0, 5'd0, 1'b0));
        pending_words.push_back(make_word(irqc_pkg::OP_WRITE, irqc_pkg::REG_SRC_STATUS,
                                          irqc_pkg::ALL_ONES, 5'd0, 1'b0));
        pending_words.push_back(make_word(irqc_pkg::OP_READ, irqc_pkg::REG_TEST_REQ,
                                          '0, 5'd0, 1'b0));
        pending_words.push_back(make_word(irqc_pkg::OP_WRITE, 5'd31,
                                          irqc_pkg::ALL_ONES, 5'd31, 1'b1));
        pending_words.push_back(make_word(irqc_pkg::OP_READ, 5'd19,
                                          irqc_pkg::ALL_ONES, 5'd0, 1'b0));
        pending_words.push_back(make_word(irqc_pkg::OP_NONE, irqc_pkg::REG_ENABLE,
                                          irqc_pkg::ALL_ONES, 5'd5, 1'b1));
        pending_words.push_back(make_word(irqc_pkg::OP_WRITE, irqc_pkg::REG_MEN_A,
                                          '0, 5'd0, 1'b0));
        pending_words.push_back(make_word(irqc_pkg::OP_WRITE, irqc_pkg::REG_MEN_B,
                                          irqc_pkg::ALL_ONES - 1, 5'd0, 1'b0));
        pending_words.push_back(make_word(irqc_pkg::OP_READ, irqc_pkg::REG_IRQ_LINE,
                                          '0, 5'd0, 1'b0));
        drain_words();

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 57; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 57; end
                default: begin idle_pct = 38; stall_pct = 38; end
            endcase
            pending_words.push_back(make_word(irqc_pkg::OP_WRITE, irqc_pkg::REG_MEN_A,
                                              irqc_pkg::ALL_ONES, 5'd0, 1'b0));
            for (int n = 0; n < WORDS_PER_PHASE; n++)
                pending_words.push_back(random_word());
            drain_words();
        end

        repeat (10) @(posedge i_clk);
        if (expected_responses.size() != 0) begin
            $error("%0d results never arrived", expected_responses.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
